// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file hbp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, ck, rstn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, ck, rstn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ===== rtl/hbp_pkg.sv =====
package hbp_pkg;

    localparam int CODE_W      = 32;
    localparam int LEN_W       = 6;
    localparam int WORD_W      = 40;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_ENCODE = 2'd1;
    localparam logic [1:0] KIND_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        symbol;
        logic [LEN_W-1:0]  code_length;
        logic [CODE_W-1:0] code_bits;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] pad_bits;
        logic       last;
    } out_t;

    typedef struct packed {
        logic              is_flush;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
    } cmd_t;

endpackage

// ===== rtl/huffman_bit_packer.sv =====
// channel | signals                      | request
// --------+------------------------------+-------------------------------
// input   | in_data, in_valid, in_ready  | load, encode or flush
// output  | out_data, out_valid, out_ready| one packed byte
//
// An encode yields up to four full bytes and a flush at most one padded byte;
// bytes leave one per cycle from the packer's shift word while out_ready allows.
// A four-entry request queue separates table lookup from packing.
// Reset clears the pending byte and all control; the code table is not cleared.
// A stalled output holds the current byte; the queue absorbs requests meanwhile.
module huffman_bit_packer
    import hbp_pkg::*;
#(
    parameter int SYMBOL_COUNT = 256,
    parameter int MAX_CODE_LEN = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  in_t  in_data,
    input  logic in_valid,
    output logic in_ready,
    output out_t out_data,
    output logic out_valid,
    input  logic out_ready
);

    cmd_t fq_data;
    logic fq_valid;
    logic fq_ready;
    cmd_t qb_data;
    logic qb_valid;
    logic qb_ready;

    hbp_front #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (fq_data),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready)
    );

    hbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (fq_data),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .pop_data   (qb_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready)
    );

    hbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (qb_data),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

// ===== rtl/hbp_front.sv =====
module hbp_front
    import hbp_pkg::*;
#(
    parameter int SYMBOL_COUNT = 256,
    parameter int MAX_CODE_LEN = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  in_t  in_data,
    input  logic in_valid,
    output logic in_ready,
    output cmd_t cmd,
    output logic cmd_valid,
    input  logic cmd_ready
);

    localparam int CLAMP_LEN = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int TLEN_W    = $clog2(CLAMP_LEN + 1);
    localparam int ADDR_W    = $clog2(SYMBOL_COUNT);

    logic [TLEN_W-1:0] len_mem  [SYMBOL_COUNT];
    logic [CODE_W-1:0] bits_mem [SYMBOL_COUNT];

    logic [TLEN_W-1:0] rd_len_reg;
    logic [CODE_W-1:0] rd_bits_reg;
    logic              stage_valid_reg, stage_valid_next;
    logic              stage_flush_reg, stage_flush_next;

    logic              accept;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len_sat;
    logic [LEN_W-1:0]  shamt;
    logic [CODE_W-1:0] aligned;

    assign accept   = in_valid && in_ready;
    assign in_ready = !stage_valid_reg || cmd_ready;
    assign in_range = {1'b0, in_data.symbol} < 9'(SYMBOL_COUNT);
    assign addr     = in_data.symbol[ADDR_W-1:0];
    assign len_sat  = (in_data.code_length > LEN_W'(CLAMP_LEN)) ? LEN_W'(CLAMP_LEN)
                                                                : in_data.code_length;
    assign shamt    = LEN_W'(CODE_W) - len_sat;
    assign aligned  = CODE_W'({{CODE_W{1'b0}}, in_data.code_bits} << shamt);

    always_ff @(posedge clk)
    begin
        if (accept && in_data.kind == KIND_LOAD && in_range)
        begin
            len_mem[addr]  <= TLEN_W'(len_sat);
            bits_mem[addr] <= aligned;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_len_reg  <= len_mem[addr];
            rd_bits_reg <= bits_mem[addr];
        end
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_flush_next = stage_flush_reg;
        if (accept)
        begin
            stage_valid_next = (in_data.kind == KIND_ENCODE && in_range)
                               || in_data.kind == KIND_FLUSH;
            stage_flush_next = in_data.kind == KIND_FLUSH;
        end
        else if (cmd_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            stage_flush_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            stage_flush_reg <= stage_flush_next;
        end
    end

    assign cmd_valid    = stage_valid_reg;
    assign cmd.is_flush = stage_flush_reg;
    assign cmd.len      = LEN_W'(rd_len_reg);
    assign cmd.bits     = rd_bits_reg;

endmodule

// ===== rtl/hbp_queue.sv =====
module hbp_queue
    import hbp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t push_data,
    input  logic push_valid,
    output logic push_ready,
    output cmd_t pop_data,
    output logic pop_valid,
    input  logic pop_ready
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/hbp_back.sv =====
module hbp_back
    import hbp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  logic cmd_valid,
    output logic cmd_ready,
    output out_t out_data,
    output logic out_valid,
    input  logic out_ready
);

    logic [7:0]        pend_byte_reg, pend_byte_next;
    logic [2:0]        pend_cnt_reg, pend_cnt_next;
    logic [CODE_W-1:0] word_reg, word_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [2:0]        pad_reg, pad_next;
    out_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              pop;
    logic              emit;
    logic [WORD_W-1:0] merged;
    logic [LEN_W-1:0]  total;
    logic [2:0]        nfull;
    logic [7:0]        tail_byte;

    assign cmd_ready = cnt_reg == '0;
    assign pop       = cmd_valid && cmd_ready;
    assign emit      = cnt_reg != '0 && (!out_valid_reg || out_ready);

    assign merged = {pend_byte_reg, {CODE_W{1'b0}}}
                  | (WORD_W'({cmd.bits, 8'b0}) >> pend_cnt_reg);
    assign total  = LEN_W'(pend_cnt_reg) + cmd.len;
    assign nfull  = total[5:3];

    always_comb
    begin
        unique case (nfull)
            3'd0:    tail_byte = merged[39:32];
            3'd1:    tail_byte = merged[31:24];
            3'd2:    tail_byte = merged[23:16];
            3'd3:    tail_byte = merged[15:8];
            3'd4:    tail_byte = merged[7:0];
            default: tail_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        pend_byte_next = pend_byte_reg;
        pend_cnt_next  = pend_cnt_reg;
        word_next      = word_reg;
        cnt_next       = cnt_reg;
        pad_next       = pad_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            if (cmd.is_flush)
            begin
                if (pend_cnt_reg != '0)
                begin
                    word_next      = {pend_byte_reg, 24'd0};
                    cnt_next       = 3'd1;
                    pad_next       = 3'(4'd8 - {1'b0, pend_cnt_reg});
                    pend_byte_next = 8'd0;
                    pend_cnt_next  = 3'd0;
                end
            end
            else
            begin
                word_next      = merged[WORD_W-1:8];
                cnt_next       = nfull;
                pad_next       = 3'd0;
                pend_byte_next = tail_byte;
                pend_cnt_next  = total[2:0];
            end
        end
        else if (emit)
        begin
            out_next.out_byte = word_reg[31:24];
            out_next.pad_bits = pad_reg;
            out_next.last     = cnt_reg == 3'd1;
            word_next         = word_reg << 8;
            cnt_next          = cnt_reg - 3'd1;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        pad_reg  <= pad_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_byte_reg <= 8'd0;
            pend_cnt_reg  <= 3'd0;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_byte_reg <= pend_byte_next;
            pend_cnt_reg  <= pend_cnt_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/hbp_checker.sv =====
`include "assert_macros.svh"

module hbp_checker
    import hbp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input in_t  in_data,
    input logic in_valid,
    input logic in_ready,
    input out_t out_data,
    input logic out_valid,
    input logic out_ready
);

    `ASSERT_CLK(a_in_hold, clk, rst_n, in_valid && !in_ready |=> in_valid && $stable(in_data))
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))
    `ASSERT_NEVER(a_pad_only_last, clk, rst_n, out_valid && out_data.pad_bits != 3'd0 && !out_data.last)
    `ASSERT_CLK(a_burst_gapless, clk, rst_n, out_valid && out_ready && !out_data.last |=> out_valid)

endmodule

bind huffman_bit_packer hbp_checker u_hbp_checker (.*);

// ===== tb/sv/huffman_bit_packer_tb.sv =====
module huffman_bit_packer_tb
    import hbp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN     = 32;
    localparam int IDLE_PCT    = 38;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_LIMIT = 20000;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    in_t  in_data   = '0;
    logic in_valid  = 1'b0;
    logic in_ready;
    out_t out_data;
    logic out_valid;
    logic out_ready = 1'b0;

    logic gaps_on  = 1'b1;
    logic hold_out = 1'b0;

    logic [LEN_W-1:0]  code_len_tab  [256];
    logic [CODE_W-1:0] code_word_tab [256];
    bit                loaded        [256];
    logic [7:0]        loaded_syms   [$];
    logic [7:0]        acc_byte  = '0;
    logic [2:0]        acc_count = '0;
    out_t              packed_bytes_q [$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    huffman_bit_packer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("huffman_bit_packer_tb: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_out)
            out_ready <= 1'b0;
        else if (!gaps_on)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (packed_bytes_q.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h", out_data.out_byte));
            else
            begin
                want = packed_bytes_q.pop_front();
                if (out_data.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              out_data.out_byte, want.out_byte));
                if (out_data.pad_bits !== want.pad_bits)
                    report_mismatch($sformatf("pad_bits %0d, want %0d",
                                              out_data.pad_bits, want.pad_bits));
                if (out_data.last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b",
                                              out_data.last, want.last));
            end
        end
    end

    function automatic void compute_packed_bytes(input in_t req);
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
        out_t              res;
        int                first;
        first = packed_bytes_q.size();
        case (req.kind)
            KIND_LOAD:
            begin
                len = (req.code_length > MAX_LEN) ? LEN_W'(MAX_LEN) : req.code_length;
                code_len_tab[req.symbol]  = len;
                code_word_tab[req.symbol] = req.code_bits;
                if (!loaded[req.symbol])
                begin
                    loaded[req.symbol] = 1'b1;
                    loaded_syms = {loaded_syms, req.symbol};
                end
            end
            KIND_ENCODE:
            begin
                len  = code_len_tab[req.symbol];
                code = code_word_tab[req.symbol];
                for (int i = int'(len) - 1; i >= 0; i--)
                begin
                    acc_byte[7 - acc_count] = code[i];
                    if (acc_count == 3'd7)
                    begin
                        res.out_byte = acc_byte;
                        res.pad_bits = 3'd0;
                        res.last     = 1'b0;
                        packed_bytes_q = {packed_bytes_q, res};
                        acc_byte  = '0;
                        acc_count = '0;
                    end
                    else
                        acc_count++;
                end
                if (packed_bytes_q.size() > first)
                    packed_bytes_q[$].last = 1'b1;
            end
            KIND_FLUSH:
            begin
                if (acc_count != 3'd0)
                begin
                    res.out_byte = acc_byte;
                    res.pad_bits = 3'(8 - acc_count);
                    res.last     = 1'b1;
                    packed_bytes_q = {packed_bytes_q, res};
                    acc_byte  = '0;
                    acc_count = '0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic in_t make_request(input logic [1:0] kind, input logic [7:0] sym,
                                         input logic [LEN_W-1:0] len,
                                         input logic [CODE_W-1:0] bits);
        in_t req;
        req.kind        = kind;
        req.symbol      = sym;
        req.code_length = len;
        req.code_bits   = bits;
        return req;
    endfunction

    function automatic in_t random_request();
        int unsigned pick;
        int unsigned lsel;
        logic [LEN_W-1:0] len;
        pick = $urandom_range(99);
        if (pick < 20 || loaded_syms.size() == 0)
        begin
            lsel = $urandom_range(99);
            if (lsel < 5)
                len = '0;
            else if (lsel < 15)
                len = LEN_W'($urandom_range(63, 17));
            else
                len = LEN_W'($urandom_range(16, 1));
            return make_request(KIND_LOAD, 8'($urandom_range(255)), len, $urandom);
        end
        else if (pick < 85)
            return make_request(KIND_ENCODE,
                                loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                                LEN_W'($urandom), $urandom);
        else if (pick < 95)
            return make_request(KIND_FLUSH, 8'($urandom), LEN_W'($urandom), $urandom);
        else
            return make_request(KIND_UNUSED, 8'($urandom), LEN_W'($urandom), $urandom);
    endfunction

    task automatic send_request(input in_t req);
        while (gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        compute_packed_bytes(req);
    endtask

    task automatic test_idle_requests();
        send_request(make_request(KIND_FLUSH, 8'h00, '0, '0));
        send_request(make_request(KIND_UNUSED, 8'hFF, '1, '1));
    endtask

    task automatic test_code_extremes();
        send_request(make_request(KIND_LOAD, 8'd0, 6'd32, 32'hFFFF_FFFF));
        send_request(make_request(KIND_LOAD, 8'd255, 6'd1, 32'h0000_0000));
        send_request(make_request(KIND_LOAD, 8'd1, 6'd0, 32'hFFFF_FFFF));
        send_request(make_request(KIND_LOAD, 8'd2, 6'd63, 32'hA5C3_0F96));
        send_request(make_request(KIND_LOAD, 8'd3, 6'd33, 32'h0000_0001));
        send_request(make_request(KIND_LOAD, 8'd5, 6'd7, 32'h8000_007F));
        send_request(make_request(KIND_ENCODE, 8'd0, '0, '0));
        send_request(make_request(KIND_ENCODE, 8'd255, '0, '0));
        // all-zero partial byte must still come out
        send_request(make_request(KIND_FLUSH, 8'd0, '0, '0));
        send_request(make_request(KIND_ENCODE, 8'd1, '0, '0));
        send_request(make_request(KIND_ENCODE, 8'd2, '0, '0));
        send_request(make_request(KIND_ENCODE, 8'd255, '1, '1));
        send_request(make_request(KIND_ENCODE, 8'd0, '0, '0));
        send_request(make_request(KIND_ENCODE, 8'd3, '0, '0));
        send_request(make_request(KIND_FLUSH, 8'd0, '0, '0));
        send_request(make_request(KIND_ENCODE, 8'd5, '0, '0));
        send_request(make_request(KIND_FLUSH, 8'd0, '0, '0));
        send_request(make_request(KIND_ENCODE, 8'd1, '0, '0));
        send_request(make_request(KIND_FLUSH, 8'd0, '0, '0));
    endtask

    task automatic test_random_stream(input int unsigned count);
        repeat (count)
            send_request(random_request());
    endtask

    task automatic test_gapless_burst();
        gaps_on <= 1'b0;
        test_random_stream(40);
        gaps_on <= 1'b1;
    endtask

    task automatic test_output_backpressure();
        fork
            begin
                hold_out <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_out <= 1'b0;
            end
            test_random_stream(40);
        join
    endtask

    task automatic wait_drain();
        int unsigned spins;
        spins = 0;
        in_valid <= 1'b0;
        while (packed_bytes_q.size() != 0 && spins < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spins++;
        end
        if (packed_bytes_q.size() != 0)
            report_mismatch($sformatf("%0d bytes never arrived", packed_bytes_q.size()));
        repeat (16)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_requests();
        test_code_extremes();
        test_random_stream(240);
        test_gapless_burst();
        test_output_backpressure();
        wait_drain();
        if (error_count == 0)
            $display("huffman_bit_packer_tb: clean");
        else
            $display("huffman_bit_packer_tb: errors");
        $finish;
    end

endmodule
